>>> rtl/wcbb_pkg.sv
`default_nettype none

package wcbb_pkg;

    // field widths
    localparam int ID_W   = 8;
    localparam int ADDR_W = 34;
    localparam int DATA_W = 64;

    // burst geometry
    localparam int BURST_WORDS_DEF = 4;
    localparam int OUT_WORDS       = 4;
    localparam int WORD_BYTES      = 8;
    localparam int ALIGN_BYTES     = 32;
    localparam int WORD_SHIFT      = $clog2(WORD_BYTES);
    localparam int ALIGN_BITS      = $clog2(ALIGN_BYTES);

    // stream packing
    localparam int ADDR_LSB     = 2 * ID_W;
    localparam int WORD_LSB     = ADDR_LSB + ADDR_W;
    localparam int IN_FIELDS_W  = WORD_LSB + DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = WORD_LSB + OUT_WORDS * DATA_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic {
        KIND_SINGLE = 1'b0,
        KIND_BURST  = 1'b1
    } write_kind_t;

endpackage

`default_nettype wire

>>> rtl/write_combining_burst_buffer_core.sv
`default_nettype none

// Write-combining burst buffer. Single 64-bit writes arrive on the s_axis
// stream; with grouping enabled, BURST_WORDS writes that start on a 32-byte
// boundary, keep the same route and destination and step by 8 bytes are
// merged into one burst item on m_axis. Words that cannot complete a burst
// leave in order as single writes. tlast on the output marks the final
// result caused by an input item. Rate: one input item per cycle while the
// output is taken every cycle and nothing is flushed. An input item that has
// to flush held words stays in the input register while they drain, one per
// cycle while the output is taken; an aligned start leaves with its last
// flushed word. grouping_enable is written through cfg_wr_en /
// cfg_wr_data and must only change while the block is idle.
module write_combining_burst_buffer_core #(
    parameter int BURST_WORDS = wcbb_pkg::BURST_WORDS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // config: grouping_enable
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_wr_data,

    // input writes
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: route_id, dest_id, byte_addr, write_data, zero pad
    input  wire logic [wcbb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tlast: stream_end
    input  wire logic                           s_axis_tlast,

    // emitted writes
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: out_route, out_dest, out_addr, word0, word1, word2, word3, zero pad
    output logic [wcbb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: write_kind
    output logic                                m_axis_tuser,
    // tlast: last_of_run
    output logic                                m_axis_tlast
);

    localparam int IDX_W = $clog2(BURST_WORDS);
    localparam int ID_W = wcbb_pkg::ID_W;
    localparam int ADDR_W = wcbb_pkg::ADDR_W;
    localparam int DATA_W = wcbb_pkg::DATA_W;
    localparam int OUT_WORDS = wcbb_pkg::OUT_WORDS;

    // config register
    logic grp_reg;

    // input register
    logic              in_valid_reg;
    logic [ID_W-1:0]   in_route_reg;
    logic [ID_W-1:0]   in_dest_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_end_reg;

    // combining buffer state
    logic [IDX_W-1:0]  fill_reg;
    logic [IDX_W-1:0]  flush_idx_reg;
    logic [ID_W-1:0]   held_route_reg;
    logic [ID_W-1:0]   held_dest_reg;
    logic [ADDR_W-1:0] held_base_reg;
    logic [DATA_W-1:0] held_words_reg [BURST_WORDS];

    // output register
    logic                 m_valid_reg;
    wcbb_pkg::write_kind_t m_kind_reg;
    logic [ID_W-1:0]      m_route_reg;
    logic [ID_W-1:0]      m_dest_reg;
    logic [ADDR_W-1:0]    m_addr_reg;
    logic [DATA_W-1:0]    m_word_reg [OUT_WORDS];
    logic                 m_last_reg;

    // decision logic
    logic              out_ok;
    logic              step;
    logic              is_aligned;
    logic              is_cont;
    logic              is_other;
    logic              fill_is_top;
    logic              flush_pending;
    logic              flush_final;
    logic              item_done;
    logic [ADDR_W-1:0] next_addr;
    logic [ADDR_W-1:0] flush_addr;

    // result being formed
    logic                  emit_valid;
    wcbb_pkg::write_kind_t emit_kind;
    logic [ID_W-1:0]       emit_route;
    logic [ID_W-1:0]       emit_dest;
    logic [ADDR_W-1:0]     emit_addr;
    logic [DATA_W-1:0]     emit_word [OUT_WORDS];
    logic [DATA_W-1:0]     burst_word [OUT_WORDS];
    logic                  emit_last;

    // output register free for a new result this cycle
    assign out_ok = !m_valid_reg || m_axis_tready;
    assign step   = in_valid_reg && out_ok;

    assign fill_is_top = (fill_reg == IDX_W'(BURST_WORDS - 1));
    assign next_addr   = held_base_reg + (ADDR_W'(fill_reg) << wcbb_pkg::WORD_SHIFT);
    assign flush_addr  = held_base_reg + (ADDR_W'(flush_idx_reg) << wcbb_pkg::WORD_SHIFT);

    // aligned start wins over continuation, everything else goes out alone
    assign is_aligned = grp_reg && !in_end_reg
                        && (in_addr_reg[wcbb_pkg::ALIGN_BITS-1:0] == '0);
    assign is_cont    = !is_aligned && grp_reg
                        && (in_route_reg == held_route_reg)
                        && (in_dest_reg == held_dest_reg)
                        && (next_addr == in_addr_reg)
                        && (!in_end_reg || fill_is_top);
    assign is_other   = !is_aligned && !is_cont;

    // held words drain one per cycle while the output is taken; a non-aligned item is handled after them
    assign flush_pending = (is_aligned || is_other) && (flush_idx_reg < fill_reg);
    assign flush_final   = (flush_idx_reg + IDX_W'(1)) == fill_reg;

    // an aligned start finishes together with its last flushed word
    assign item_done = step && (!flush_pending || (is_aligned && flush_final));

    assign s_axis_tready = !in_valid_reg || item_done;

    // burst words: held words then the incoming one in the top slot
    for (genvar j = 0; j < OUT_WORDS; j++) begin : g_burst
        if (j < BURST_WORDS - 1) begin : g_held
            assign burst_word[j] = held_words_reg[j];
        end else if (j == BURST_WORDS - 1) begin : g_new
            assign burst_word[j] = in_data_reg;
        end else begin : g_zero
            assign burst_word[j] = '0;
        end
    end

    always_comb begin
        emit_valid = 1'b0;
        emit_kind  = wcbb_pkg::KIND_SINGLE;
        emit_route = in_route_reg;
        emit_dest  = in_dest_reg;
        emit_addr  = in_addr_reg;
        emit_last  = 1'b1;
        for (int k = 0; k < OUT_WORDS; k++) begin
            emit_word[k] = '0;
        end
        if (flush_pending) begin
            // single write of one held word
            emit_valid   = 1'b1;
            emit_route   = held_route_reg;
            emit_dest    = held_dest_reg;
            emit_addr    = flush_addr;
            emit_word[0] = held_words_reg[flush_idx_reg];
            emit_last    = is_aligned && flush_final;
        end else if (is_cont && fill_is_top) begin
            // buffer fills: one burst
            emit_valid = 1'b1;
            emit_kind  = wcbb_pkg::KIND_BURST;
            emit_route = held_route_reg;
            emit_dest  = held_dest_reg;
            emit_addr  = held_base_reg;
            for (int k = 0; k < OUT_WORDS; k++) begin
                emit_word[k] = burst_word[k];
            end
        end else if (is_other) begin
            // pass-through single write
            emit_valid   = 1'b1;
            emit_word[0] = in_data_reg;
        end
    end

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            grp_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_route_reg <= s_axis_tdata[ID_W-1:0];
            in_dest_reg  <= s_axis_tdata[wcbb_pkg::ADDR_LSB-1:ID_W];
            in_addr_reg  <= s_axis_tdata[wcbb_pkg::WORD_LSB-1:wcbb_pkg::ADDR_LSB];
            in_data_reg  <= s_axis_tdata[wcbb_pkg::IN_FIELDS_W-1:wcbb_pkg::WORD_LSB];
            in_end_reg   <= s_axis_tlast;
        end
    end

    // buffer control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            flush_idx_reg  <= '0;
            held_route_reg <= '0;
            held_dest_reg  <= '0;
            held_base_reg  <= '0;
        end else if (item_done) begin
            flush_idx_reg <= '0;
            if (is_aligned) begin
                held_route_reg <= in_route_reg;
                held_dest_reg  <= in_dest_reg;
                held_base_reg  <= in_addr_reg;
                fill_reg       <= IDX_W'(1);
            end else if (is_cont) begin
                fill_reg <= fill_is_top ? '0 : fill_reg + IDX_W'(1);
            end else begin
                fill_reg <= '0;
            end
        end else if (step && flush_pending) begin
            flush_idx_reg <= flush_idx_reg + IDX_W'(1);
        end
    end

    // held data words
    always_ff @(posedge aclk) begin
        if (item_done && is_aligned) begin
            held_words_reg[0] <= in_data_reg;
        end else if (item_done && is_cont) begin
            held_words_reg[fill_reg] <= in_data_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ok) begin
            m_valid_reg <= step && emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit_valid) begin
            m_kind_reg  <= emit_kind;
            m_route_reg <= emit_route;
            m_dest_reg  <= emit_dest;
            m_addr_reg  <= emit_addr;
            m_last_reg  <= emit_last;
            for (int k = 0; k < OUT_WORDS; k++) begin
                m_word_reg[k] <= emit_word[k];
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{wcbb_pkg::OUT_PAD_W{1'b0}},
                            m_word_reg[3], m_word_reg[2], m_word_reg[1], m_word_reg[0],
                            m_addr_reg, m_dest_reg, m_route_reg};

endmodule

`default_nettype wire

>>> rtl/wcbb_checker.sv
`default_nettype none

module wcbb_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [wcbb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tuser,
    input wire logic                            m_axis_tlast
);

    localparam int HI_LSB = wcbb_pkg::WORD_LSB + wcbb_pkg::DATA_W;
    localparam int HI_MSB = wcbb_pkg::OUT_FIELDS_W - 1;

    // output stays put while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // no output item straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a burst always closes the run of its input item
    a_burst_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == wcbb_pkg::KIND_BURST) |-> m_axis_tlast)
        else $error("burst not marked last");

    // bursts start on an alignment boundary
    a_burst_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == wcbb_pkg::KIND_BURST) |->
            m_axis_tdata[wcbb_pkg::ADDR_LSB +: wcbb_pkg::ALIGN_BITS] == '0)
        else $error("burst address not aligned");

    // single writes carry only the first word
    a_single_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == wcbb_pkg::KIND_SINGLE) |->
            m_axis_tdata[HI_MSB:HI_LSB] == '0)
        else $error("single write with nonzero upper words");

endmodule

bind write_combining_burst_buffer_core wcbb_checker u_wcbb_checker (.*);

`default_nettype wire
